// File: hdl/mtp_pkg.sv
// shared types, constants and the tempering function of the mt19937 generator
// no dependencies; imported by mtp_fill, mtp_scale, the top level and the testbench
`default_nettype none

package mtp_pkg;

	localparam int WORD_W       = 32;
	localparam int POOL_WORDS   = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int ADDR_W       = $clog2(POOL_WORDS);

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [ADDR_W-1:0] pool_addr_t;

	localparam word_t TWIST_MATRIX = 32'h9908_b0df;
	localparam word_t HIGH_BIT     = 32'h8000_0000;
	localparam word_t LOW_BITS     = 32'h7fff_ffff;
	localparam word_t INIT_MULT    = 32'd1812433253;
	localparam word_t TEMPER_B     = 32'h9d2c_5680;
	localparam word_t TEMPER_C     = 32'hefc6_0000;
	localparam word_t SEED_RESET   = 32'd1;

	localparam pool_addr_t LAST_ADDR  = pool_addr_t'(POOL_WORDS - 1);
	localparam pool_addr_t TWIST_FWD  = pool_addr_t'(TWIST_OFFSET);
	localparam pool_addr_t TWIST_BACK = pool_addr_t'(POOL_WORDS - TWIST_OFFSET);

	typedef struct packed {
		logic       en;
		pool_addr_t addr;
		word_t      data;
	} ram_wr_t;

	typedef struct packed {
		logic  valid;
		word_t word;
		word_t lo;
		word_t span;
	} draw_t;

	function automatic word_t temper(input word_t w);
		word_t y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

`default_nettype wire

// File: hdl/mtp_if.sv
// valid/ready channels of the generator: request and result words
// no dependencies
`default_nettype none

interface mtp_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] range_low;
	logic [31:0] range_high;

	modport source (output valid, output range_low, output range_high, input ready);
	modport sink (input valid, input range_low, input range_high, output ready);
endinterface

interface mtp_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] random_word;
	logic [31:0] ranged_value;

	modport source (output valid, output random_word, output ranged_value, input ready);
	modport sink (input valid, input random_word, input ranged_value, output ready);
endinterface

`default_nettype wire

// File: hdl/mtp_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module mtp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: hdl/mtp_fill.sv
// seed register and pool initialisation sequencer, each non-seed word through a multiply and an add state
// depends on mtp_pkg
`default_nettype none

module mtp_fill import mtp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  seed_we,
	input  wire word_t seed_wdata,
	output logic       busy,
	output ram_wr_t    wr
);

	localparam logic [1:0] FS_SEED = 2'd0;
	localparam logic [1:0] FS_MUL  = 2'd1;
	localparam logic [1:0] FS_ADD  = 2'd2;
	localparam logic [1:0] FS_DONE = 2'd3;

	logic [1:0]  st_q;
	word_t       seed_q;
	pool_addr_t  k_q;
	word_t       prev_q;
	word_t       prod_q;
	word_t       mix;
	logic [63:0] prod_full;
	word_t       next_word;

	assign mix       = prev_q ^ (prev_q >> 30);
	assign prod_full = 64'(INIT_MULT) * 64'(mix);
	assign next_word = prod_q + word_t'(k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= FS_SEED;
			seed_q <= SEED_RESET;
			k_q    <= '0;
		end else if (seed_we) begin
			st_q   <= FS_SEED;
			seed_q <= seed_wdata;
		end else begin
			case (st_q)
				FS_SEED: begin
					k_q  <= pool_addr_t'(1);
					st_q <= FS_MUL;
				end
				FS_MUL: begin
					st_q <= FS_ADD;
				end
				FS_ADD: begin
					if (k_q == LAST_ADDR) begin
						st_q <= FS_DONE;
					end else begin
						k_q  <= k_q + pool_addr_t'(1);
						st_q <= FS_MUL;
					end
				end
				default: begin
					st_q <= FS_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			FS_SEED: prev_q <= seed_q;
			FS_MUL:  prod_q <= prod_full[31:0];
			FS_ADD:  prev_q <= next_word;
			default: prev_q <= prev_q;
		endcase
	end

	always_comb begin
		wr.en   = 1'b0;
		wr.addr = k_q;
		wr.data = next_word;
		case (st_q)
			FS_SEED: begin
				wr.en   = 1'b1;
				wr.addr = '0;
				wr.data = seed_q;
			end
			FS_ADD: begin
				wr.en = 1'b1;
			end
			default: begin
				wr.en = 1'b0;
			end
		endcase
	end

	assign busy = (st_q != FS_DONE);

endmodule

`default_nettype wire

// File: hdl/mtp_scale.sv
// range scaling pipeline (multiply, add) and output word queue
// depends on mtp_pkg and mtp_if
`default_nettype none

module mtp_scale import mtp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire draw_t draw,
	output logic       room,
	mtp_rsp_if.source  rsp
);

	logic                  v_s2;
	word_t                 word_s2;
	word_t                 lo_s2;
	word_t                 span_s2;
	logic                  v_s3;
	word_t                 word_s3;
	word_t                 lo_s3;
	word_t                 hi_s3;
	logic [63:0]           prod_full;
	word_t                 fifo_word [FIFO_DEPTH];
	word_t                 fifo_rng [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic [FIFO_CNT_W+1:0] total;
	logic                  pop;

	assign prod_full = 64'(word_s2) * 64'(span_s2);
	assign pop       = rsp.valid & rsp.ready;

	// in flight plus queued must leave a slot for a new word
	assign total = (FIFO_CNT_W+2)'(cnt_q) + (FIFO_CNT_W+2)'(draw.valid)
		+ (FIFO_CNT_W+2)'(v_s2) + (FIFO_CNT_W+2)'(v_s3);
	assign room  = (total < (FIFO_CNT_W+2)'(FIFO_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			v_s2 <= draw.valid;
			v_s3 <= v_s2;
			if (v_s3) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			cnt_q <= cnt_q + FIFO_CNT_W'(v_s3) - FIFO_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		word_s2 <= draw.word;
		lo_s2   <= draw.lo;
		span_s2 <= draw.span;
		word_s3 <= word_s2;
		lo_s3   <= lo_s2;
		hi_s3   <= prod_full[63:32];
		if (v_s3) begin
			fifo_word[wr_ptr_q] <= word_s3;
			fifo_rng[wr_ptr_q]  <= lo_s3 + hi_s3;
		end
	end

	assign rsp.valid        = (cnt_q != '0);
	assign rsp.random_word  = fifo_word[rd_ptr_q];
	assign rsp.ranged_value = fifo_rng[rd_ptr_q];

endmodule

`default_nettype wire

// File: hdl/mersenne_twister_prng.sv
// mt19937 generator, top level: pool index, twist-on-draw stage and pool rams
// result path: twist stage, scaling stages s2 and s3, then the output word queue
// throughput: one word per cycle while ready; each draw twists one pool word in place
// reset or seed write: pool fill, seed word then multiply and add a word; ready low
// depends on mtp_pkg, mtp_if, mtp_ram, mtp_fill, mtp_scale
`default_nettype none

module mersenne_twister_prng import mtp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mtp_req_if.sink    req,
	mtp_rsp_if.source  rsp,
	input  wire logic  seed_we,
	input  wire word_t seed_wdata
);

	logic       fill_busy;
	ram_wr_t    fill_wr;
	ram_wr_t    ram_wr;
	logic       room;
	logic       req_fire;
	pool_addr_t idx_q;
	pool_addr_t nxt_addr;
	pool_addr_t far_addr;
	word_t      rd_nxt;
	word_t      rd_far;
	word_t      cur_q;
	logic       v_s1;
	pool_addr_t idx_s1;
	word_t      lo_s1;
	word_t      hi_s1;
	word_t      mixed;
	word_t      twisted;
	draw_t      draw;

	mtp_fill u_fill (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_we    (seed_we),
		.seed_wdata (seed_wdata),
		.busy       (fill_busy),
		.wr         (fill_wr)
	);

	assign req.ready = !fill_busy && room;
	assign req_fire  = req.valid && req.ready;

	assign nxt_addr = (idx_q == LAST_ADDR) ? '0 : idx_q + pool_addr_t'(1);
	assign far_addr = (idx_q < TWIST_BACK) ? idx_q + TWIST_FWD : idx_q - TWIST_BACK;

	always_comb begin
		if (fill_wr.en) begin
			ram_wr = fill_wr;
		end else begin
			ram_wr.en   = v_s1;
			ram_wr.addr = idx_s1;
			ram_wr.data = twisted;
		end
	end

	// two copies of the pool give the neighbour and the far word in the same cycle
	mtp_ram #(
		.WIDTH (WORD_W),
		.DEPTH (POOL_WORDS)
	) u_ram_nxt (
		.clk   (clk),
		.we    (ram_wr.en),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.raddr (nxt_addr),
		.rdata (rd_nxt)
	);

	mtp_ram #(
		.WIDTH (WORD_W),
		.DEPTH (POOL_WORDS)
	) u_ram_far (
		.clk   (clk),
		.we    (ram_wr.en),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.raddr (far_addr),
		.rdata (rd_far)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= req_fire;
			if (fill_busy) begin
				idx_q <= '0;
			end else if (req_fire) begin
				idx_q <= nxt_addr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			idx_s1 <= idx_q;
			lo_s1  <= req.range_low;
			hi_s1  <= req.range_high;
		end
		// cur_q holds the not yet twisted word at idx_q
		if (fill_wr.en && fill_wr.addr == '0) begin
			cur_q <= fill_wr.data;
		end else if (v_s1) begin
			cur_q <= rd_nxt;
		end
	end

	assign mixed   = (cur_q & HIGH_BIT) | (rd_nxt & LOW_BITS);
	assign twisted = rd_far ^ (mixed >> 1) ^ (mixed[0] ? TWIST_MATRIX : '0);

	assign draw.valid = v_s1;
	assign draw.word  = temper(twisted);
	assign draw.lo    = lo_s1;
	assign draw.span  = hi_s1 - lo_s1;

	mtp_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.draw   (draw),
		.room   (room),
		.rsp    (rsp)
	);

`ifndef SYNTHESIS
	a_idx_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && idx_q == LAST_ADDR) |=> (idx_q == '0))
		else $error("pool index did not wrap after the last word");

	a_no_wr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(fill_wr.en && v_s1))
		else $error("fill and twist write the pool in the same cycle");

	a_s1_index: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (v_s1 && idx_s1 == $past(idx_q)))
		else $error("twist stage lost the index of its draw");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// testbench of the mt19937 generator: directed bounds, several seeds, pool wrap and a long
// result stall, each word checked against a behavioural copy of the generator
// depends on mtp_pkg, mtp_if and mersenne_twister_prng

module tb_top;

	typedef mtp_pkg::word_t word_t;

	typedef struct packed {
		word_t random_word;
		word_t ranged_value;
	} draw_result_t;

	localparam int    POOL_N         = 624;
	localparam int    FAR_OFS        = 397;
	localparam word_t TWIST_XOR      = 32'h9908_b0df;
	localparam word_t TOP_BIT        = 32'h8000_0000;
	localparam word_t LOW_31_BITS    = 32'h7fff_ffff;
	localparam word_t SEED_MULT      = 32'd1812433253;
	localparam word_t TEMPER_MASK_B  = 32'h9d2c_5680;
	localparam word_t TEMPER_MASK_C  = 32'hefc6_0000;
	localparam int    RESULT_LATENCY = 4;
	localparam int    IDLE_LIMIT     = 10000;
	localparam int    LONG_HOLD      = 300;

	logic  clk;
	logic  arst_n;
	logic  seed_we;
	word_t seed_wdata;

	mtp_req_if req_ch ();
	mtp_rsp_if rsp_ch ();

	word_t        mt_pool [POOL_N];
	int unsigned  mt_next;
	draw_result_t pending_draws [$];
	int unsigned  fail_count = 0;
	int unsigned  draws_checked = 0;
	int unsigned  seeds_written = 0;
	int unsigned  sink_hold_cycles = 0;
	int unsigned  idle_cycles = 0;
	bit           src_gaps_on;
	bit           sink_stalls_on;

	mersenne_twister_prng dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.seed_we    (seed_we),
		.seed_wdata (seed_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void load_seed(input word_t s);
		word_t prev;
		mt_pool[0] = s;
		for (int i = 1; i < POOL_N; i++) begin
			prev = mt_pool[i-1];
			mt_pool[i] = SEED_MULT * (prev ^ (prev >> 30)) + word_t'(i);
		end
		mt_next = POOL_N;
	endfunction

	function automatic void regen_pool();
		word_t y;
		for (int i = 0; i < POOL_N; i++) begin
			y = (mt_pool[i] & TOP_BIT) | (mt_pool[(i + 1) % POOL_N] & LOW_31_BITS);
			mt_pool[i] = mt_pool[(i + FAR_OFS) % POOL_N] ^ (y >> 1) ^ (y[0] ? TWIST_XOR : '0);
		end
		mt_next = 0;
	endfunction

	function automatic word_t scramble(input word_t w);
		word_t t;
		t = w ^ (w >> 11);
		t = t ^ ((t << 7) & TEMPER_MASK_B);
		t = t ^ ((t << 15) & TEMPER_MASK_C);
		return t ^ (t >> 18);
	endfunction

	function automatic draw_result_t predict_draw(input word_t lo, input word_t hi);
		draw_result_t r;
		logic [63:0]  prod;
		if (mt_next >= POOL_N)
			regen_pool();
		r.random_word = scramble(mt_pool[mt_next]);
		mt_next++;
		prod = {32'd0, r.random_word} * {32'd0, word_t'(hi - lo)};
		r.ranged_value = lo + prod[63:32];
		return r;
	endfunction

	task automatic send_draw(input word_t lo, input word_t hi);
		int unsigned gap;
		gap = src_gaps_on ? $urandom_range(4, 0) : 0;
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.range_low  <= lo;
		req_ch.range_high <= hi;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		pending_draws.push_back(predict_draw(lo, hi));
	endtask

	task automatic wait_quiet();
		req_ch.valid <= 1'b0;
		while (pending_draws.size() != 0) @(posedge clk);
		repeat (RESULT_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_seed(input word_t s);
		wait_quiet();
		while (!req_ch.ready) @(posedge clk);
		seed_we    <= 1'b1;
		seed_wdata <= s;
		@(posedge clk);
		seed_we <= 1'b0;
		load_seed(s);
		seeds_written++;
	endtask

	task automatic send_random_draws(input int unsigned n, input bit vary_idling);
		word_t lo;
		word_t hi;
		for (int unsigned k = 0; k < n; k++) begin
			if (vary_idling && (k % 64 == 0)) begin
				src_gaps_on    = ($urandom_range(3, 0) != 0);
				sink_stalls_on = ($urandom_range(3, 0) != 0);
			end
			lo = $urandom();
			case ($urandom_range(5, 0))
				0: hi = $urandom();
				1: hi = lo + $urandom_range(16, 1);
				2: hi = lo;
				3: hi = lo - $urandom_range(1000, 1);
				4: begin
					lo = ($urandom_range(1, 0) != 0) ? '1 : '0;
					hi = ($urandom_range(1, 0) != 0) ? '1 : TOP_BIT;
				end
				default: hi = lo + ($urandom() >> $urandom_range(31, 0));
			endcase
			send_draw(lo, hi);
		end
	endtask

	task automatic test_bound_extremes();
		word_t lows [13] = '{32'h0, 32'h0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'h1, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'haaaa_aaaa, 32'h5555_5555,
			32'h0, 32'h1234_5678};
		word_t highs [13] = '{32'h0, 32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'hffff_fffe,
			32'h0, 32'h1, 32'h7fff_ffff, 32'h8000_0000, 32'h5555_5555, 32'haaaa_aaaa,
			32'h8000_0000, 32'h1234_5678};
		src_gaps_on    = 1'b1;
		sink_stalls_on = 1'b1;
		for (int i = 0; i < 13; i++)
			send_draw(lows[i], highs[i]);
	endtask

	task automatic test_reset_seed_stream();
		send_random_draws(300, 1'b1);
	endtask

	task automatic test_seed_extremes();
		write_seed(32'h0);
		send_random_draws(200, 1'b1);
		write_seed(32'hffff_ffff);
		send_random_draws(200, 1'b1);
		write_seed(32'd1);
		send_random_draws(150, 1'b1);
	endtask

	// long enough to run past the end of the pool and twist again
	task automatic test_pool_wrap();
		write_seed($urandom());
		send_random_draws(750, 1'b1);
	endtask

	task automatic test_result_back_pressure();
		write_seed($urandom());
		src_gaps_on      = 1'b0;
		sink_stalls_on   = 1'b0;
		sink_hold_cycles = LONG_HOLD;
		send_random_draws(100, 1'b0);
	endtask

	initial begin : result_sink
		int unsigned stall;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (sink_hold_cycles != 0) begin
				stall = sink_hold_cycles;
				sink_hold_cycles = 0;
			end else begin
				stall = sink_stalls_on ? $urandom_range(4, 0) : 0;
			end
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		draw_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_draws.size() == 0) begin
				$error("unexpected result word, random_word %h", rsp_ch.random_word);
				fail_count++;
			end else begin
				want = pending_draws.pop_front();
				draws_checked++;
				if (rsp_ch.random_word !== want.random_word) begin
					$error("random_word: expected %h, actual %h",
						want.random_word, rsp_ch.random_word);
					fail_count++;
				end
				if (rsp_ch.ranged_value !== want.ranged_value) begin
					$error("ranged_value: expected %h, actual %h",
						want.ranged_value, rsp_ch.ranged_value);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.range_low  <= '0;
		req_ch.range_high <= '0;
		seed_we           <= 1'b0;
		seed_wdata        <= '0;
		load_seed(32'd1);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_bound_extremes();
		test_reset_seed_stream();
		test_seed_extremes();
		test_pool_wrap();
		test_result_back_pressure();
		wait_quiet();

		$display("summary: %0d draws checked over the reset seed and %0d seed writes",
			draws_checked, seeds_written);
		$display("summary: extreme and wrapped bounds, pool re-twist, long result stall");
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
